// ===== rtl/brpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brpt_pkg
// Shared types and constants of the buzzer ring pattern timer.
// ----------------------------------------------------------------------------
package brpt_pkg;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_FAST   = 2'd1,
    MODE_NORMAL = 2'd2
  } mode_t;

  localparam int unsigned LEASE_W = 20;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned INDEX_W = 2;

  localparam logic [INDEX_W-1:0] REG_LEASE_MS      = 2'd0;
  localparam logic [INDEX_W-1:0] REG_ACTIVE_BUZZER = 2'd1;

  localparam logic [LEASE_W-1:0] LEASE_RESET = 20'd3000;

  localparam logic [TIME_W-1:0] FAST_ON_MS  = 32'd28;
  localparam logic [TIME_W-1:0] FAST_OFF_MS = 32'd42;
  localparam logic [TIME_W-1:0] FAST_HOP_MS = 32'd60;
  localparam logic [TIME_W-1:0] NORM_ON_MS  = 32'd100;
  localparam logic [TIME_W-1:0] NORM_OFF_MS = 32'd140;
  localparam logic [TIME_W-1:0] NORM_HOP_MS = 32'd70;

endpackage

// ===== rtl/buzzer_ring_pattern_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_ring_pattern_timer
// Buzzer cadence generator with lease timeout and frequency hopping.
// ----------------------------------------------------------------------------
// Each input beat is a mode command (cmd = 1) or a time tick (cmd = 0), both
// stamped with now_ms. Every input beat yields exactly one output beat that
// reports tone_enable, freq_alt, mode_now and lease_expired after that beat.
// The cadence state is updated in the cycle the beat is accepted; the result,
// held in an output register, appears in the cycle after. Without a receiver
// stall the block sustains one beat per cycle; the limit is the single pass
// through due-time adders and compares between state and output registers.
// When the receiver stalls, the output register holds its beat and in_ready
// falls until that beat is taken; a new beat is accepted in the same cycle
// the held one leaves. The write port sets lease_ms (index 0) and
// active_buzzer (index 1) and should be used only while the block is idle.
// A synchronous reset turns the buzzer off, clears the cadence, empties the
// output register and restores lease_ms to 3000 and active_buzzer to 0.
// ----------------------------------------------------------------------------
module buzzer_ring_pattern_timer
  import brpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [INDEX_W-1:0]  wr_index,
  input  logic [LEASE_W-1:0]  wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic [1:0]          mode_req,
  input  logic [TIME_W-1:0]   now_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                tone_enable,
  output logic                freq_alt,
  output logic [1:0]          mode_now,
  output logic                lease_expired
);

  logic [LEASE_W-1:0] lease_ms;
  logic               active_buzzer;

  mode_t              ring_mode, ring_mode_next;
  logic               tone_on, tone_on_next;
  logic [TIME_W-1:0]  toggle_due, toggle_due_next;
  logic [TIME_W-1:0]  hop_due, hop_due_next;
  logic [TIME_W-1:0]  lease_end, lease_end_next;
  logic               alt_select, alt_select_next;
  logic               expired_next;

  logic [TIME_W-1:0]  lease_time;
  logic [TIME_W-1:0]  lease_diff;
  logic [TIME_W-1:0]  on_ms, off_ms, hop_ms;
  logic               accept;

  assign accept     = in_valid && in_ready;
  assign in_ready   = !out_valid || out_ready;
  assign lease_time = now_ms + TIME_W'(lease_ms);
  assign lease_diff = now_ms - lease_end;

  always_comb begin
    on_ms  = NORM_ON_MS;
    off_ms = NORM_OFF_MS;
    hop_ms = NORM_HOP_MS;
    if (ring_mode == MODE_FAST) begin
      on_ms  = FAST_ON_MS;
      off_ms = FAST_OFF_MS;
      hop_ms = FAST_HOP_MS;
    end
  end

  always_comb begin
    ring_mode_next  = ring_mode;
    tone_on_next    = tone_on;
    toggle_due_next = toggle_due;
    hop_due_next    = hop_due;
    lease_end_next  = lease_end;
    alt_select_next = alt_select;
    expired_next    = 1'b0;
    if (cmd) begin
      if (mode_req <= MODE_NORMAL) begin
        if (mode_req == ring_mode) begin
          if (ring_mode != MODE_OFF) begin
            lease_end_next = lease_time;
          end
        end else begin
          ring_mode_next  = mode_t'(mode_req);
          alt_select_next = 1'b0;
          if (mode_req == MODE_FAST) begin
            tone_on_next    = 1'b1;
            lease_end_next  = lease_time;
            toggle_due_next = now_ms + FAST_ON_MS;
            hop_due_next    = now_ms + FAST_HOP_MS;
          end else if (mode_req == MODE_NORMAL) begin
            tone_on_next    = 1'b1;
            lease_end_next  = lease_time;
            toggle_due_next = now_ms + NORM_ON_MS;
            hop_due_next    = now_ms + NORM_HOP_MS;
          end else begin
            tone_on_next    = 1'b0;
            lease_end_next  = '0;
            toggle_due_next = '0;
            hop_due_next    = '0;
          end
        end
      end
    end else if (ring_mode != MODE_OFF) begin
      if (!lease_diff[TIME_W-1]) begin
        ring_mode_next  = MODE_OFF;
        tone_on_next    = 1'b0;
        toggle_due_next = '0;
        hop_due_next    = '0;
        lease_end_next  = '0;
        alt_select_next = 1'b0;
        expired_next    = 1'b1;
      end else begin
        if (now_ms >= toggle_due) begin
          tone_on_next    = !tone_on;
          toggle_due_next = now_ms + (tone_on ? off_ms : on_ms);
          if (!tone_on) begin
            hop_due_next = now_ms + hop_ms;
          end
        end
        if (!active_buzzer && tone_on_next && (now_ms >= hop_due_next)) begin
          alt_select_next = !alt_select;
          hop_due_next    = now_ms + hop_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lease_ms      <= LEASE_RESET;
      active_buzzer <= 1'b0;
    end else if (wr_en) begin
      if (wr_index == REG_LEASE_MS) begin
        lease_ms <= wr_data;
      end else if (wr_index == REG_ACTIVE_BUZZER) begin
        active_buzzer <= wr_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_mode  <= MODE_OFF;
      tone_on    <= 1'b0;
      toggle_due <= '0;
      hop_due    <= '0;
      lease_end  <= '0;
      alt_select <= 1'b0;
    end else if (accept) begin
      ring_mode  <= ring_mode_next;
      tone_on    <= tone_on_next;
      toggle_due <= toggle_due_next;
      hop_due    <= hop_due_next;
      lease_end  <= lease_end_next;
      alt_select <= alt_select_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tone_enable   <= tone_on_next;
      freq_alt      <= alt_select_next;
      mode_now      <= ring_mode_next;
      lease_expired <= expired_next;
    end
  end

`ifndef ASSERT_OFF
  a_expired_turns_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && lease_expired |-> mode_now == MODE_OFF)
    else $error("lease expiry reported while still ringing");

  a_off_is_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode_now == MODE_OFF |-> !tone_enable && !freq_alt)
    else $error("tone or alternate frequency reported while off");

  a_state_off_clean: assert property (@(posedge clk) disable iff (rst)
    ring_mode == MODE_OFF |-> !tone_on && !alt_select)
    else $error("cadence state not cleared while off");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");
`endif

endmodule
